// ----- hw/rtl/amr_pkg.sv -----
// Shared types, constants and helpers for the axis moment resultant unit.
package amr_pkg;

    localparam int NUM_CFG = 6;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X    = 3'd3;
    localparam logic [2:0] CFG_DIR_Y    = 3'd4;
    localparam logic [2:0] CFG_DIR_Z    = 3'd5;

    localparam logic [31:0] DIR_Z_RESET = 32'sd65536;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] own_moment_x;
        logic signed [31:0] own_moment_y;
        logic signed [31:0] own_moment_z;
        logic               last_element;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] torque;
        logic signed [63:0] axis_thrust;
        logic signed [63:0] sum_force_x;
        logic signed [63:0] sum_force_y;
        logic signed [63:0] sum_force_z;
        logic signed [63:0] sum_moment_x;
        logic signed [63:0] sum_moment_y;
        logic signed [63:0] sum_moment_z;
        logic               result_valid;
    } t_out_beat;

    typedef struct packed {
        logic               valid;
        logic [4:0]         tag;
        logic signed [67:0] prod;
    } t_mul_res;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_res;

    typedef struct packed {
        logic               done;
        logic signed [63:0] quo;
    } t_div_res;

    // Clamp a wide signed value to 64 bit signed
    function automatic logic signed [63:0] sat64(input logic signed [127:0] a);
        logic signed [63:0] r;
        if (a[127:63] == '0 || a[127:63] == '1) begin
            r = a[63:0];
        end else if (a[127]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/amr_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat.
interface amr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/amr_mul.sv -----
// Shared registered 34x34 signed multiplier with a step tag.
module amr_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [4:0]              i_tag,
    input  logic signed [33:0]      i_a,
    input  logic signed [33:0]      i_b,
    output amr_pkg::t_mul_res       o_res
);
    amr_pkg::t_mul_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= i_en;
        end
        r_res.tag  <= i_tag;
        r_res.prod <= i_a * i_b;
    end

    assign o_res = r_res;
endmodule

// ----- hw/rtl/amr_sqrt.sv -----
// Bit-pair integer square root of a 64 bit value, one step per cycle.
module amr_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_x,
    output amr_pkg::t_sqrt_res o_res
);
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [4:0]  r_k;
    logic        r_busy;
    logic        r_done;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic        ge;

    assign bitv  = 64'd1 << {r_k, 1'b0};
    assign trial = r_res + bitv;
    assign ge    = r_x >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_k   <= 5'd31;
        end else if (r_busy) begin
            if (ge) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + bitv;
            end else begin
                r_res <= r_res >> 1;
            end
            r_k <= r_k - 5'd1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_res[31:0];
endmodule

// ----- hw/rtl/amr_div.sv -----
// Restoring divider: |acc| * 2^F / len, one quotient bit per cycle, saturated.
module amr_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_acc,
    input  logic [31:0]        i_len,
    output amr_pkg::t_div_res  o_res
);
    localparam int NB = 64 + FRAC_BITS;
    localparam int CW = $clog2(NB);
    localparam logic [CW-1:0] CNT_LAST = CW'(NB - 1);

    logic [NB-1:0] r_nq;
    logic [31:0]   r_rem;
    logic [31:0]   r_len;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   rem_sh;
    logic          ge;
    logic [63:0]   mag;
    logic [63:0]   lo;
    logic          big;

    assign mag    = i_acc[63] ? 64'(-i_acc) : 64'(i_acc);
    assign rem_sh = {r_rem, r_nq[NB-1]};
    assign ge     = rem_sh >= {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_nq  <= {mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_len <= i_len;
            r_neg <= i_acc[63];
            r_cnt <= CNT_LAST;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_len}) : rem_sh[31:0];
            r_nq  <= {r_nq[NB-2:0], ge};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign lo  = r_nq[63:0];
    assign big = (r_nq[NB-1:64] != '0) || (lo > 64'h8000_0000_0000_0000);

    always_comb begin
        o_res.done = r_done;
        if (big) begin
            o_res.quo = r_neg ? amr_pkg::SAT_MIN : amr_pkg::SAT_MAX;
        end else if (r_neg) begin
            o_res.quo = (lo == 64'h8000_0000_0000_0000) ? amr_pkg::SAT_MIN : -$signed(lo);
        end else begin
            o_res.quo = lo[63] ? amr_pkg::SAT_MAX : $signed(lo);
        end
    end
endmodule

// ----- hw/rtl/axis_moment_resultant_unit.sv -----
// Top level: force/moment resultants about a configured rotation axis.
// Per element that is not last: the accept while ready, 15 issues on the shared
//   multiplier, one drain and one accumulate; ready is low meanwhile.
// Final scaling: a last element's result beat follows 3 square issues, the root and
//   two divides (torque, then axial force); a degenerate axis skips root and divides;
//   ready returns with the load of the beat, later while the previous beat is stalled.
// Reset (synchronous, active low) clears sums, sequencer and output valid; origin 0, dir z 65536.
module axis_moment_resultant_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    amr_stream_if.sink   i_in,
    amr_stream_if.source o_out
);
    localparam int F = COORD_FRAC_BITS;
    localparam logic [63:0] DEGEN_SQ = (64'd1 << (2 * F)) / 64'd1000000000000;

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ELEM  = 4'd1;
    localparam logic [3:0] ST_FLUSH = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_SQFL  = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_DIVT  = 4'd8;
    localparam logic [3:0] ST_DIVA  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // Multiplier schedule: cross product, torque dot, axial dot, squared length
    localparam logic [4:0] MS_C0A = 5'd0;
    localparam logic [4:0] MS_C0B = 5'd1;
    localparam logic [4:0] MS_C1A = 5'd2;
    localparam logic [4:0] MS_C1B = 5'd3;
    localparam logic [4:0] MS_C2A = 5'd4;
    localparam logic [4:0] MS_C2B = 5'd5;
    localparam logic [4:0] MS_T0L = 5'd6;
    localparam logic [4:0] MS_T0H = 5'd7;
    localparam logic [4:0] MS_T1L = 5'd8;
    localparam logic [4:0] MS_T1H = 5'd9;
    localparam logic [4:0] MS_T2L = 5'd10;
    localparam logic [4:0] MS_T2H = 5'd11;
    localparam logic [4:0] MS_A0  = 5'd12;
    localparam logic [4:0] MS_A1  = 5'd13;
    localparam logic [4:0] MS_A2  = 5'd14;
    localparam logic [4:0] MS_S0  = 5'd15;
    localparam logic [4:0] MS_S1  = 5'd16;
    localparam logic [4:0] MS_S2  = 5'd17;

    // Move a value with frac fraction bits to Q32.32 (floor on right shift)
    function automatic logic signed [127:0] to_q32(input logic signed [127:0] v,
                                                   input int frac);
        logic signed [127:0] r;
        if (frac > 32) begin
            r = v >>> (frac - 32);
        end else begin
            r = v <<< (32 - frac);
        end
        return r;
    endfunction

    logic [31:0]        r_cfg [amr_pkg::NUM_CFG];
    logic [3:0]         r_state, n_state;
    logic [4:0]         r_step;
    logic signed [32:0] r_l [3];
    logic signed [31:0] r_f [3];
    logic signed [31:0] r_m [3];
    logic               r_last;

    // Per-element products
    logic signed [65:0]  r_c [3];
    logic signed [103:0] r_tq;
    logic signed [65:0]  r_ax;
    logic [63:0]         r_sq;

    // Running sums, Q32.32
    logic signed [63:0] r_tq_acc;
    logic signed [63:0] r_ax_acc;
    logic signed [63:0] r_f_acc [3];
    logic signed [63:0] r_m_acc [3];

    logic signed [63:0] r_tq_out;
    logic signed [63:0] r_ax_out_q;
    logic               r_rvalid;
    logic               r_ovalid;
    amr_pkg::t_out_beat r_odata;

    logic signed [31:0] dir [3];
    logic               in_acc;
    logic               mul_en;
    logic signed [33:0] mul_a, mul_b;
    amr_pkg::t_mul_res  s_mul;
    amr_pkg::t_sqrt_res s_sqrt;
    amr_pkg::t_div_res  s_div;
    logic               sqrt_start;
    logic               div_start;
    logic signed [63:0] div_acc;
    logic [31:0]        r_len;
    logic               out_free;

    assign dir[0] = r_cfg[amr_pkg::CFG_DIR_X];
    assign dir[1] = r_cfg[amr_pkg::CFG_DIR_Y];
    assign dir[2] = r_cfg[amr_pkg::CFG_DIR_Z];

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < amr_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[amr_pkg::CFG_DIR_Z] <= amr_pkg::DIR_Z_RESET;
        end else if (i_cfg_we && i_cfg_idx <= amr_pkg::CFG_DIR_Z) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            MS_C0A: begin mul_a = 34'(r_l[1]); mul_b = 34'(r_f[2]); end
            MS_C0B: begin mul_a = 34'(r_l[2]); mul_b = 34'(r_f[1]); end
            MS_C1A: begin mul_a = 34'(r_l[2]); mul_b = 34'(r_f[0]); end
            MS_C1B: begin mul_a = 34'(r_l[0]); mul_b = 34'(r_f[2]); end
            MS_C2A: begin mul_a = 34'(r_l[0]); mul_b = 34'(r_f[1]); end
            MS_C2B: begin mul_a = 34'(r_l[1]); mul_b = 34'(r_f[0]); end
            // wide cross terms go in as low 33 bits unsigned, then high part signed
            MS_T0L: begin mul_a = {1'b0, r_c[0][32:0]}; mul_b = 34'(dir[0]); end
            MS_T0H: begin mul_a = 34'(r_c[0] >>> 33);   mul_b = 34'(dir[0]); end
            MS_T1L: begin mul_a = {1'b0, r_c[1][32:0]}; mul_b = 34'(dir[1]); end
            MS_T1H: begin mul_a = 34'(r_c[1] >>> 33);   mul_b = 34'(dir[1]); end
            MS_T2L: begin mul_a = {1'b0, r_c[2][32:0]}; mul_b = 34'(dir[2]); end
            MS_T2H: begin mul_a = 34'(r_c[2] >>> 33);   mul_b = 34'(dir[2]); end
            MS_A0:  begin mul_a = 34'(r_f[0]); mul_b = 34'(dir[0]); end
            MS_A1:  begin mul_a = 34'(r_f[1]); mul_b = 34'(dir[1]); end
            MS_A2:  begin mul_a = 34'(r_f[2]); mul_b = 34'(dir[2]); end
            MS_S0:  begin mul_a = 34'(dir[0]); mul_b = 34'(dir[0]); end
            MS_S1:  begin mul_a = 34'(dir[1]); mul_b = 34'(dir[1]); end
            MS_S2:  begin mul_a = 34'(dir[2]); mul_b = 34'(dir[2]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_en = (r_state == ST_ELEM) || (r_state == ST_SQ);

    amr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (mul_en),
        .i_tag   (r_step),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_res   (s_mul)
    );

    assign sqrt_start = (r_state == ST_CHK) && (r_sq > DEGEN_SQ);

    amr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (r_sq),
        .o_res   (s_sqrt)
    );

    // One divider serves torque, then axial force
    assign div_start = ((r_state == ST_SQRT) && s_sqrt.done)
                    || ((r_state == ST_DIVT) && s_div.done);
    assign div_acc   = (r_state == ST_SQRT) ? r_tq_acc : r_ax_acc;

    amr_div #(
        .FRAC_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_acc   (div_acc),
        .i_len   ((r_state == ST_SQRT) ? s_sqrt.root : r_len),
        .o_res   (s_div)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) begin n_state = ST_ELEM; end
            ST_ELEM:  if (r_step == MS_A2) begin n_state = ST_FLUSH; end
            ST_FLUSH: n_state = ST_ACC;
            ST_ACC:   n_state = r_last ? ST_SQ : ST_IDLE;
            ST_SQ:    if (r_step == MS_S2) begin n_state = ST_SQFL; end
            ST_SQFL:  n_state = ST_CHK;
            ST_CHK:   n_state = sqrt_start ? ST_SQRT : ST_OUT;
            ST_SQRT:  if (s_sqrt.done) begin n_state = ST_DIVT; end
            ST_DIVT:  if (s_div.done) begin n_state = ST_DIVA; end
            ST_DIVA:  if (s_div.done) begin n_state = ST_OUT; end
            ST_OUT:   if (out_free) begin n_state = ST_IDLE; end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= MS_C0A;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_step <= MS_C0A;
            end else if (r_state == ST_ACC) begin
                r_step <= MS_S0;
            end else if (mul_en) begin
                r_step <= r_step + 5'd1;
            end
        end
    end

    // Element capture: lever arm is formed here, exact in 33 bits
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_l[0] <= 33'(i_in.data.ref_x) - 33'($signed(r_cfg[amr_pkg::CFG_ORIGIN_X]));
            r_l[1] <= 33'(i_in.data.ref_y) - 33'($signed(r_cfg[amr_pkg::CFG_ORIGIN_Y]));
            r_l[2] <= 33'(i_in.data.ref_z) - 33'($signed(r_cfg[amr_pkg::CFG_ORIGIN_Z]));
            r_f[0] <= i_in.data.force_x;
            r_f[1] <= i_in.data.force_y;
            r_f[2] <= i_in.data.force_z;
            r_m[0] <= i_in.data.own_moment_x;
            r_m[1] <= i_in.data.own_moment_y;
            r_m[2] <= i_in.data.own_moment_z;
            r_last <= i_in.data.last_element;
        end
    end

    // Product consumption, in the cycle after issue
    always_ff @(posedge i_clk) begin
        if (s_mul.valid) begin
            case (s_mul.tag)
                MS_C0A: r_c[0] <= s_mul.prod[65:0];
                MS_C0B: r_c[0] <= r_c[0] - s_mul.prod[65:0];
                MS_C1A: r_c[1] <= s_mul.prod[65:0];
                MS_C1B: r_c[1] <= r_c[1] - s_mul.prod[65:0];
                MS_C2A: r_c[2] <= s_mul.prod[65:0];
                MS_C2B: r_c[2] <= r_c[2] - s_mul.prod[65:0];
                MS_T0L: r_tq <= 104'(s_mul.prod);
                MS_T0H, MS_T1H, MS_T2H: r_tq <= r_tq + (104'(s_mul.prod) <<< 33);
                MS_T1L, MS_T2L: r_tq <= r_tq + 104'(s_mul.prod);
                MS_A0:  r_ax <= s_mul.prod[65:0];
                MS_A1, MS_A2: r_ax <= r_ax + s_mul.prod[65:0];
                MS_S0:  r_sq <= s_mul.prod[63:0];
                MS_S1, MS_S2: r_sq <= r_sq + s_mul.prod[63:0];
                default: r_sq <= r_sq;
            endcase
        end
    end

    // Saturating sums; cleared when the result beat is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == ST_OUT && out_free)) begin
            r_tq_acc <= '0;
            r_ax_acc <= '0;
            for (int i = 0; i < 3; i++) begin
                r_f_acc[i] <= '0;
                r_m_acc[i] <= '0;
            end
        end else if (r_state == ST_ACC) begin
            r_tq_acc <= amr_pkg::sat64(128'(r_tq_acc) + to_q32(128'(r_tq), 3 * F));
            r_ax_acc <= amr_pkg::sat64(128'(r_ax_acc) + to_q32(128'(r_ax), 2 * F));
            for (int i = 0; i < 3; i++) begin
                r_f_acc[i] <= amr_pkg::sat64(128'(r_f_acc[i]) + to_q32(128'(r_f[i]), F));
                r_m_acc[i] <= amr_pkg::sat64(128'(r_m_acc[i])
                    + (to_q32(128'(r_c[i]), 2 * F) + to_q32(128'(r_m[i]), F)));
            end
        end
    end

    // Final scaling results
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQRT && s_sqrt.done) begin
            r_len <= s_sqrt.root;
        end
        if (r_state == ST_DIVT && s_div.done) begin
            r_tq_out <= s_div.quo;
        end
        if (r_state == ST_CHK) begin
            r_rvalid <= sqrt_start;
        end
    end

    // Output register: holds the beat while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == ST_OUT && out_free) begin
            if (r_rvalid) begin
                r_odata.torque       <= r_tq_out;
                r_odata.axis_thrust  <= r_ax_out_q;
                r_odata.sum_force_x  <= r_f_acc[0];
                r_odata.sum_force_y  <= r_f_acc[1];
                r_odata.sum_force_z  <= r_f_acc[2];
                r_odata.sum_moment_x <= r_m_acc[0];
                r_odata.sum_moment_y <= r_m_acc[1];
                r_odata.sum_moment_z <= r_m_acc[2];
                r_odata.result_valid <= 1'b1;
            end else begin
                r_odata <= '0;
            end
        end
    end

    // Axial quotient, captured at the second divide's finish
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIVA && s_div.done) begin
            r_ax_out_q <= s_div.quo;
        end
    end

    // No multiplier product may be pending while the block takes a new element
    a_idle_no_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !s_mul.valid)
        else $error("product pending in idle");

    // Root completes only while the sequencer waits for it
    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sqrt.done |-> (r_state == ST_SQRT))
        else $error("square root finished out of sequence");

    // Quotients complete only during the two divide phases
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div.done |-> (r_state == ST_DIVT || r_state == ST_DIVA))
        else $error("divide finished out of sequence");

    // The last element's accumulate is followed by the first square issue of final scaling
    a_last_goes_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && r_last) |=> (r_state == ST_SQ && r_step == MS_S0))
        else $error("last element did not start final scaling");

endmodule

// ----- sim/tb_axis_moment_resultant_unit.sv -----
// Self-checking testbench for the axis moment resultant unit.
module tb_axis_moment_resultant_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_WAIT = 300;
    localparam int HOLD_LEN   = 3000;

    // Idling phases
    typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} t_phase;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the axis registers and running sums, predicts
    // one result beat per last element and checks output beats in order.
    // ------------------------------------------------------------------
    class resultant_scoreboard;
        logic signed [31:0] axis_reg [amr_pkg::NUM_CFG];
        logic signed [63:0] torque_sum, axial_sum;
        logic signed [63:0] force_sum [3];
        logic signed [63:0] moment_sum [3];
        amr_pkg::t_out_beat pending [$];
        int                 errors;

        function new();
            int i;
            for (i = 0; i < amr_pkg::NUM_CFG; i++) axis_reg[i] = '0;
            axis_reg[amr_pkg::CFG_DIR_Z] = amr_pkg::DIR_Z_RESET;
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            int i;
            torque_sum = '0;
            axial_sum  = '0;
            for (i = 0; i < 3; i++) begin
                force_sum[i]  = '0;
                moment_sum[i] = '0;
            end
        endfunction

        function void write_reg(int idx, logic [31:0] val);
            axis_reg[idx] = val;
        endfunction

        // Saturating accumulate of a wide term
        function logic signed [63:0] clamp_add(logic signed [63:0] acc,
                                               logic signed [127:0] term);
            logic signed [127:0] s;
            s = acc;
            s = s + term;
            if (s > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return s[63:0];
        endfunction

        function logic [63:0] floor_sqrt(logic [127:0] x);
            logic [127:0] r, cand;
            int i;
            r = '0;
            for (i = 33; i >= 0; i--) begin
                cand = r | (128'd1 << i);
                if (cand * cand <= x) r = cand;
            end
            return r[63:0];
        endfunction

        // acc * 2^F / len, toward zero, saturated
        function logic signed [63:0] axis_scale(logic signed [63:0] acc, logic [63:0] len);
            logic [127:0] mag, q;
            logic neg;
            neg = acc[63];
            mag = {64'd0, neg ? (~acc + 64'd1) : acc};
            mag = mag << FRAC;
            q = mag / {64'd0, len};
            if (q > (128'd1 << 63)) return neg ? amr_pkg::SAT_MIN : amr_pkg::SAT_MAX;
            if (neg) return (q == (128'd1 << 63)) ? amr_pkg::SAT_MIN : -q[63:0];
            return (q == (128'd1 << 63)) ? amr_pkg::SAT_MAX : q[63:0];
        endfunction

        function void note_input(amr_pkg::t_in_beat b);
            logic signed [127:0] l [3];
            logic signed [127:0] f [3];
            logic signed [127:0] m [3];
            logic signed [127:0] d [3];
            logic signed [127:0] o [3];
            logic signed [127:0] c [3];
            logic signed [127:0] tq, ax, sumsq;
            logic [63:0] len;
            amr_pkg::t_out_beat r;
            int i;
            l[0] = b.ref_x;   l[1] = b.ref_y;   l[2] = b.ref_z;
            f[0] = b.force_x; f[1] = b.force_y; f[2] = b.force_z;
            m[0] = b.own_moment_x; m[1] = b.own_moment_y; m[2] = b.own_moment_z;
            for (i = 0; i < 3; i++) begin
                o[i] = axis_reg[i];
                d[i] = axis_reg[3 + i];
                l[i] = l[i] - o[i];
            end
            c[0] = l[1] * f[2] - l[2] * f[1];
            c[1] = l[2] * f[0] - l[0] * f[2];
            c[2] = l[0] * f[1] - l[1] * f[0];
            tq = c[0] * d[0] + c[1] * d[1] + c[2] * d[2];
            ax = f[0] * d[0] + f[1] * d[1] + f[2] * d[2];
            // torque term is Q.3F, drop F bits with floor
            torque_sum = clamp_add(torque_sum, tq >>> FRAC);
            axial_sum  = clamp_add(axial_sum, ax);
            for (i = 0; i < 3; i++) begin
                force_sum[i]  = clamp_add(force_sum[i], f[i] <<< FRAC);
                moment_sum[i] = clamp_add(moment_sum[i], c[i] + (m[i] <<< FRAC));
            end
            if (!b.last_element) return;
            r = '0;
            sumsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            // degenerate threshold floors to zero at this precision
            if (sumsq > 0) begin
                len = floor_sqrt(sumsq);
                r.torque       = axis_scale(torque_sum, len);
                r.axis_thrust  = axis_scale(axial_sum, len);
                r.sum_force_x  = force_sum[0];
                r.sum_force_y  = force_sum[1];
                r.sum_force_z  = force_sum[2];
                r.sum_moment_x = moment_sum[0];
                r.sum_moment_y = moment_sum[1];
                r.sum_moment_z = moment_sum[2];
                r.result_valid = 1'b1;
            end
            pending.push_back(r);
            clear_sums();
        endfunction

        function void check_result(amr_pkg::t_out_beat got);
            amr_pkg::t_out_beat want;
            logic [63:0] wv [9];
            logic [63:0] gv [9];
            string nm [9];
            int i;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            nm = '{"torque", "axis_thrust", "sum_force_x", "sum_force_y", "sum_force_z",
                   "sum_moment_x", "sum_moment_y", "sum_moment_z", "result_valid"};
            wv = '{want.torque, want.axis_thrust, want.sum_force_x, want.sum_force_y,
                   want.sum_force_z, want.sum_moment_x, want.sum_moment_y,
                   want.sum_moment_z, 64'(want.result_valid)};
            gv = '{got.torque, got.axis_thrust, got.sum_force_x, got.sum_force_y,
                   got.sum_force_z, got.sum_moment_x, got.sum_moment_y,
                   got.sum_moment_z, 64'(got.result_valid)};
            for (i = 0; i < 9; i++) begin
                if (wv[i] !== gv[i]) begin
                    $display("%0t: %s mismatch: expected %h actual %h",
                             $realtime, nm[i], wv[i], gv[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    amr_stream_if #(.T(amr_pkg::t_in_beat))  in_ch ();
    amr_stream_if #(.T(amr_pkg::t_out_beat)) out_ch ();

    axis_moment_resultant_unit #(.COORD_FRAC_BITS(FRAC)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    resultant_scoreboard sb;
    t_phase phase;
    bit     hold_req;
    int     hold_cnt;
    int     quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready per idling phase, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else begin
            case (phase)
                PH_RECV_STALL: begin
                    out_ch.ready <= ($urandom_range(99) >= 84);
                end
                PH_BOTH: begin
                    out_ch.ready <= ($urandom_range(99) >= 14);
                end
                default: begin
                    out_ch.ready <= 1'b1;
                end
            endcase
        end
    end

    // Output monitor and watchdog on beats of either channel or configuration writes
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("axis_moment_resultant_unit test failed");
            $finish;
        end
    end

    task automatic write_reg(int idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[2:0];
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_axis(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        write_reg(amr_pkg::CFG_ORIGIN_X, ox);
        write_reg(amr_pkg::CFG_ORIGIN_Y, oy);
        write_reg(amr_pkg::CFG_ORIGIN_Z, oz);
        write_reg(amr_pkg::CFG_DIR_X, dx);
        write_reg(amr_pkg::CFG_DIR_Y, dy);
        write_reg(amr_pkg::CFG_DIR_Z, dz);
    endtask

    // Stop offering, wait for all results, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Offer one beat; valid is only lowered while idling before it
    task automatic send_beat(amr_pkg::t_in_beat b);
        while ((phase == PH_SEND_IDLE && $urandom_range(99) < 84) ||
               (phase == PH_BOTH && $urandom_range(99) < 14)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(b);
    endtask

    function automatic logic [31:0] pick_val();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(262143)) - 131072);
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic amr_pkg::t_in_beat random_beat(bit last);
        amr_pkg::t_in_beat b;
        b.ref_x = pick_val();        b.ref_y = pick_val();        b.ref_z = pick_val();
        b.force_x = pick_val();      b.force_y = pick_val();      b.force_z = pick_val();
        b.own_moment_x = pick_val(); b.own_moment_y = pick_val(); b.own_moment_z = pick_val();
        b.last_element = last;
        return b;
    endfunction

    function automatic amr_pkg::t_in_beat fill_beat(logic [31:0] v, bit last);
        amr_pkg::t_in_beat b;
        b = {{9{v}}, last};
        return b;
    endfunction

    // Random element sets of 1..8 beats
    task automatic random_sets(int n_items);
        int sent, len, k;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(8, 1);
            for (k = 0; k < len; k++) send_beat(random_beat(k == len - 1));
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        phase = PH_NONE;
        hold_req = 1'b0;
        hold_cnt = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset axis, single and multi-element sets at field extremes
        send_beat(fill_beat(32'h0001_0000, 1'b1));
        send_beat(fill_beat(32'h7FFF_FFFF, 1'b0));
        send_beat(fill_beat(32'h7FFF_FFFF, 1'b1));
        send_beat(fill_beat(32'h8000_0000, 1'b1));
        send_beat(fill_beat(32'hFFFF_FFFF, 1'b0));
        send_beat(fill_beat(32'h0000_0000, 1'b1));
        send_beat(random_beat(1'b0));
        send_beat(random_beat(1'b1));
        drain();
        // Extreme origin and direction
        write_axis(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(fill_beat(32'h7FFF_FFFF, 1'b0));
        send_beat(fill_beat(32'h7FFF_FFFF, 1'b0));
        send_beat(fill_beat(32'h8000_0000, 1'b1));
        send_beat(random_beat(1'b1));
        drain();
        // Degenerate axis: all-zero result, sums still cleared
        write_axis(32'h0000_1000, 32'hFFFF_0000, 32'd3, 32'd0, 32'd0, 32'd0);
        send_beat(random_beat(1'b0));
        send_beat(random_beat(1'b1));
        drain();
        // Smallest nonzero direction: largest scaling
        write_axis(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        send_beat(fill_beat(32'h7FFF_FFFF, 1'b1));
        send_beat(random_beat(1'b1));
        drain();
        // Register change in the middle of a set
        send_beat(random_beat(1'b0));
        drain();
        write_axis($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        send_beat(random_beat(1'b1));
        drain();

        // Random sets over the idling phases
        phase = PH_NONE;
        write_axis($urandom(), $urandom(), $urandom(), 32'h0001_0000, 32'h0, 32'h0);
        random_sets(110);
        // fill the block and stall its output for a long stretch
        hold_req = 1'b1;
        random_sets(110);
        drain();

        phase = PH_SEND_IDLE;
        write_axis(pick_val(), pick_val(), pick_val(), $urandom(), $urandom(), $urandom());
        random_sets(220);
        drain();

        phase = PH_RECV_STALL;
        write_axis(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'($signed($urandom_range(511)) - 256), 32'd5, 32'hFFFF_FFFF);
        random_sets(220);
        drain();

        phase = PH_BOTH;
        write_axis($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_sets(220);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("axis_moment_resultant_unit test passed");
        end else begin
            $display("axis_moment_resultant_unit test failed");
        end
        $finish;
    end

endmodule
